@@ hdl/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg - shared types and constants of the charger status classifier
// Charge state codes, packed status word, per-pin flags, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    ST_NO_POWER     = 2'd0,
    ST_CHARGING     = 2'd1,
    ST_FULL         = 2'd2,
    ST_BATT_MISSING = 2'd3
  } charge_state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_LEVEL = 2'd0,
    CFG_POWER_HOLD   = 2'd1,
    CFG_STABLE_HIGH  = 2'd2,
    CFG_ALT_WINDOW   = 2'd3
  } cfg_index_e;

  localparam logic             RST_DETECT_LEVEL = 1'b1;
  localparam logic [CFG_W-1:0] RST_POWER_HOLD   = 16'd1000;
  localparam logic [CFG_W-1:0] RST_STABLE_HIGH  = 16'd400;
  localparam logic [CFG_W-1:0] RST_ALT_WINDOW   = 16'd1500;

  // bit 5 down to bit 0
  typedef struct packed {
    logic          batt_missing;
    logic          battery_full;
    logic          charging;
    logic          power_good;
    charge_state_e charge_state;
  } status_t;

  typedef struct packed {
    logic in_window;   // seen active within the alternation window
    logic stable;      // active for at least the stable time
  } pin_flags_t;

endpackage

`default_nettype wire

@@ hdl/csc_in_if.sv @@
// ----------------------------------------------------------------------------
// csc_in_if - tick request channel
// Pin levels and elapsed time, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface csc_in_if;
  logic        valid;
  logic        ready;
  logic        detect_level;
  logic        full_level;
  logic [15:0] elapsed_ms;

  modport source (output valid, detect_level, full_level, elapsed_ms, input ready);
  modport sink   (input valid, detect_level, full_level, elapsed_ms, output ready);
endinterface

`default_nettype wire

@@ hdl/csc_out_if.sv @@
// ----------------------------------------------------------------------------
// csc_out_if - status result channel
// Classified charge state and flags, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface csc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] charge_state;
  logic       power_good;
  logic       charging;
  logic       battery_full;
  logic       batt_missing;
  logic       status_changed;

  modport source (output valid, charge_state, power_good, charging, battery_full,
                  batt_missing, status_changed, input ready);
  modport sink   (input valid, charge_state, power_good, charging, battery_full,
                  batt_missing, status_changed, output ready);
endinterface

`default_nettype wire

@@ hdl/csc_pin_track.sv @@
// ----------------------------------------------------------------------------
// csc_pin_track - per-pin age and high-period tracker
// Saturating age since the pin was last active, run length of the current
// active period, and the window / stable flags derived from them.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_pin_track import csc_pkg::*; #(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 active_i,
  input  wire logic [ELAPSED_W-1:0] elapsed_ms_i,
  input  wire logic [CFG_W-1:0]     stable_high_ms_i,
  input  wire logic [CFG_W-1:0]     window_ms_i,
  output pin_flags_t                flags_o
);

  localparam int unsigned CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] AGE_MAX = {{(SW-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

  logic [TIME_BITS-1:0] age_q, age_d, high_q, high_d;
  logic                 ever_q, ever_d, run_q, run_d;
  logic [SW-1:0]        age_sum, high_sum;

  assign age_sum  = SW'(age_q) + SW'(elapsed_ms_i);
  assign high_sum = SW'(high_q) + SW'(elapsed_ms_i);

  always_comb begin
    age_d  = (age_sum > AGE_MAX) ? AGE_MAX[TIME_BITS-1:0] : age_sum[TIME_BITS-1:0];
    high_d = '0;
    ever_d = ever_q;
    run_d  = 1'b0;
    if (active_i) begin
      age_d  = '0;
      ever_d = 1'b1;
      run_d  = 1'b1;
      // a fresh period starts at zero
      if (run_q) begin
        high_d = (high_sum > AGE_MAX) ? AGE_MAX[TIME_BITS-1:0] : high_sum[TIME_BITS-1:0];
      end
    end
  end

  assign flags_o.stable    = run_d && (CW'(high_d) >= CW'(stable_high_ms_i));
  assign flags_o.in_window = ever_d && (CW'(age_d) <= CW'(window_ms_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q  <= '0;
      high_q <= '0;
      ever_q <= 1'b0;
      run_q  <= 1'b0;
    end else if (step_i) begin
      age_q  <= age_d;
      high_q <= high_d;
      ever_q <= ever_d;
      run_q  <= run_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/charger_status_classifier.sv @@
// ----------------------------------------------------------------------------
// charger_status_classifier - charger pin status classifier
// Tracks charger pin activity and classifies no power / charging / full /
// no battery once per tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per tick with both pin levels and the ms elapsed
//            since the previous tick (0 on the first tick).
//   out_ch : one result per request: charge state, flags and a changed bit
//            against the previous result.
//   cfg    : write-only registers (detect level, power hold, stable time,
//            alternation window), written while the block is idle.
// A result is valid in the cycle after its request is accepted. Throughput is
// one request per cycle unless the receiver stalls: the state update and
// classification sit between the tracker registers and the result register.
// The result register doubles as the stall buffer; in_ch.ready stays high
// while it is empty or being drained, so a stalled receiver holds off only
// the request after the one waiting.
// Reset clears all ages, periods and the last status, and loads the
// register defaults (active-high detect, 1000 / 400 / 1500 ms).
// ----------------------------------------------------------------------------
`default_nettype none

module charger_status_classifier import csc_pkg::*; #(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  csc_in_if.sink                    in_ch,
  csc_out_if.source                 out_ch,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] AGE_MAX = {{(SW-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

  // configuration
  logic             det_level_q;
  logic [CFG_W-1:0] hold_ms_q, stable_ms_q, window_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_level_q <= RST_DETECT_LEVEL;
      hold_ms_q   <= RST_POWER_HOLD;
      stable_ms_q <= RST_STABLE_HIGH;
      window_ms_q <= RST_ALT_WINDOW;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_DETECT_LEVEL: det_level_q <= cfg_wdata_i[0];
        CFG_POWER_HOLD:   hold_ms_q   <= cfg_wdata_i;
        CFG_STABLE_HIGH:  stable_ms_q <= cfg_wdata_i;
        CFG_ALT_WINDOW:   window_ms_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake
  logic out_valid_q;
  logic accept;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  logic det_high, full_on;
  assign det_high = (in_ch.detect_level == det_level_q);
  assign full_on  = in_ch.full_level;

  pin_flags_t det_flags, full_flags;

  csc_pin_track #(.TIME_BITS(TIME_BITS)) u_det (
    .clk_i,
    .rst_ni,
    .step_i           (accept),
    .active_i         (det_high),
    .elapsed_ms_i     (in_ch.elapsed_ms),
    .stable_high_ms_i (stable_ms_q),
    .window_ms_i      (window_ms_q),
    .flags_o          (det_flags)
  );

  csc_pin_track #(.TIME_BITS(TIME_BITS)) u_full (
    .clk_i,
    .rst_ni,
    .step_i           (accept),
    .active_i         (full_on),
    .elapsed_ms_i     (in_ch.elapsed_ms),
    .stable_high_ms_i (stable_ms_q),
    .window_ms_i      (window_ms_q),
    .flags_o          (full_flags)
  );

  // power age: any active pin counts as power
  logic [TIME_BITS-1:0] power_age_q, power_age_d;
  logic                 power_seen_q, power_seen_d;
  logic [SW-1:0]        power_sum;

  assign power_sum = SW'(power_age_q) + SW'(in_ch.elapsed_ms);

  always_comb begin
    if (det_high || full_on) begin
      power_age_d = '0;
    end else if (power_sum > AGE_MAX) begin
      power_age_d = AGE_MAX[TIME_BITS-1:0];
    end else begin
      power_age_d = power_sum[TIME_BITS-1:0];
    end
    power_seen_d = power_seen_q || det_high || full_on;
  end

  // classification
  logic    pwr, nobat;
  status_t status_d;

  assign pwr   = power_seen_d && (CW'(power_age_d) <= CW'(hold_ms_q));
  assign nobat = pwr && det_flags.in_window && full_flags.in_window &&
                 !det_flags.stable && !full_flags.stable;

  always_comb begin
    if (!pwr) begin
      status_d.charge_state = ST_NO_POWER;
    end else if (nobat) begin
      status_d.charge_state = ST_BATT_MISSING;
    end else if (full_flags.stable) begin
      status_d.charge_state = ST_FULL;
    end else begin
      status_d.charge_state = ST_CHARGING;
    end
    status_d.power_good   = pwr;
    status_d.charging     = (status_d.charge_state == ST_CHARGING) ||
                            (status_d.charge_state == ST_BATT_MISSING);
    status_d.battery_full = (status_d.charge_state == ST_FULL);
    status_d.batt_missing = nobat;
  end

  status_t last_status_q;
  status_t status_q;
  logic    changed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_age_q   <= '0;
      power_seen_q  <= 1'b0;
      last_status_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        power_age_q   <= power_age_d;
        power_seen_q  <= power_seen_d;
        last_status_q <= status_d;
        out_valid_q   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      changed_q <= (status_d != last_status_q);
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.charge_state   = status_q.charge_state;
  assign out_ch.power_good     = status_q.power_good;
  assign out_ch.charging       = status_q.charging;
  assign out_ch.battery_full   = status_q.battery_full;
  assign out_ch.batt_missing   = status_q.batt_missing;
  assign out_ch.status_changed = changed_q;

  // checks
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no result");

  a_changed_vs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (changed_q == (status_q != $past(last_status_q))))
    else $error("status_changed disagrees with previous status");

  a_power_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(power_seen_q))
    else $error("power_seen cleared outside reset");

  a_active_pin_clears_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (det_high || full_on)) |=> (power_seen_q && (power_age_q == '0)))
    else $error("active pin did not clear power age");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench of the charger status classifier
// Feeds pin-level ticks through the request channel, predicts status results
// with an in-bench classifier or takes them from the table, and checks the
// results in order. A short table covers reset, extremes and each state.
// Random bursts of charge, full, alternating, quiet, both-pin and noise pin
// patterns follow under six register settings and three backpressure mixes.
// ----------------------------------------------------------------------------

module tb;
  import csc_pkg::*;

  localparam int          CLK_HALF        = 10;
  localparam int          ITEMS_PER_PHASE = 322;
  localparam int          NUM_PHASES      = 6;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam logic [15:0] AGE_MAX         = 16'hFFFF;

  typedef struct packed {
    status_t status;
    logic    changed;
  } tick_result_t;

  typedef struct packed {
    logic          det_level;
    logic          full_level;
    logic [15:0]   dt;
    logic          typed;
    charge_state_e want_state;
    logic          want_changed;
  } dir_row_t;

  typedef enum int {
    PIN_CHARGE,
    PIN_FULL,
    PIN_ALTERNATE,
    PIN_QUIET,
    PIN_BOTH,
    PIN_NOISE
  } pin_pattern_e;

  // reset registers: detect active high, hold 1000, stable 400, window 1500
  localparam dir_row_t DIRECTED [16] = '{
    '{1'b0, 1'b0, 16'd0,     1'b1, ST_NO_POWER, 1'b0},  // quiet after reset
    '{1'b0, 1'b0, 16'd65535, 1'b1, ST_NO_POWER, 1'b0},  // never seen: still no power
    '{1'b1, 1'b0, 16'd0,     1'b1, ST_CHARGING, 1'b1},  // first detect
    '{1'b1, 1'b0, 16'd400,   1'b0, ST_NO_POWER, 1'b0},  // detect becomes stable
    '{1'b0, 1'b1, 16'd100,   1'b0, ST_NO_POWER, 1'b0},  // swap: alternation
    '{1'b1, 1'b0, 16'd100,   1'b0, ST_NO_POWER, 1'b0},
    '{1'b0, 1'b1, 16'd65535, 1'b0, ST_NO_POWER, 1'b0},  // detect age saturates
    '{1'b0, 1'b1, 16'd65535, 1'b0, ST_NO_POWER, 1'b0},  // full run saturates
    '{1'b0, 1'b0, 16'd999,   1'b0, ST_NO_POWER, 1'b0},
    '{1'b0, 1'b0, 16'd1,     1'b0, ST_NO_POWER, 1'b0},  // power age at the hold time
    '{1'b0, 1'b0, 16'd1,     1'b1, ST_NO_POWER, 1'b1},  // one past the hold time
    '{1'b0, 1'b0, 16'd65535, 1'b1, ST_NO_POWER, 1'b0},
    '{1'b1, 1'b1, 16'd0,     1'b0, ST_NO_POWER, 1'b0},  // both pins at once
    '{1'b1, 1'b1, 16'd400,   1'b0, ST_NO_POWER, 1'b0},
    '{1'b1, 1'b1, 16'd65535, 1'b0, ST_NO_POWER, 1'b0},
    '{1'b1, 1'b0, 16'd1,     1'b0, ST_NO_POWER, 1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_index_e  cfg_index_i;
  logic [15:0] cfg_wdata_i;

  csc_in_if  in_ch ();
  csc_out_if out_ch ();

  charger_status_classifier u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // classifier state as the bench sees it
  logic        cfg_active_level;
  logic [15:0] cfg_hold_ms;
  logic [15:0] cfg_stable_ms;
  logic [15:0] cfg_window_ms;
  logic [15:0] since_power_ms;
  logic [15:0] since_detect_ms;
  logic [15:0] since_full_ms;
  logic [15:0] detect_run_ms;
  logic [15:0] full_run_ms;
  logic        power_ever;
  logic        detect_ever;
  logic        full_ever;
  logic        detect_on_run;
  logic        full_on_run;
  status_t     prev_status;

  tick_result_t status_expect_q [$];
  int unsigned  err_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  function automatic logic [15:0] add_sat(logic [15:0] a, logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[16] ? AGE_MAX : sum[15:0];
  endfunction

  // all flags follow from the state
  function automatic tick_result_t make_status(charge_state_e st, logic changed);
    tick_result_t r;
    r.status.charge_state = st;
    r.status.power_good   = (st != ST_NO_POWER);
    r.status.charging     = (st == ST_CHARGING) || (st == ST_BATT_MISSING);
    r.status.battery_full = (st == ST_FULL);
    r.status.batt_missing = (st == ST_BATT_MISSING);
    r.changed             = changed;
    return r;
  endfunction

  task automatic classify_tick(input logic det_level, input logic full_level,
                               input logic [15:0] dt, output tick_result_t res);
    logic          det_on;
    logic          pwr;
    logic          det_stable;
    logic          full_steady;
    logic          alt;
    logic          nobat;
    charge_state_e st;
    det_on          = (det_level == cfg_active_level);
    since_power_ms  = add_sat(since_power_ms, dt);
    since_detect_ms = add_sat(since_detect_ms, dt);
    since_full_ms   = add_sat(since_full_ms, dt);
    if (det_on) begin
      since_power_ms  = '0;
      power_ever      = 1'b1;
      since_detect_ms = '0;
      detect_ever     = 1'b1;
      if (detect_on_run) begin
        detect_run_ms = add_sat(detect_run_ms, dt);
      end else begin
        detect_on_run = 1'b1;
        detect_run_ms = '0;
      end
    end else begin
      detect_on_run = 1'b0;
      detect_run_ms = '0;
    end
    if (full_level) begin
      since_power_ms = '0;
      power_ever     = 1'b1;
      since_full_ms  = '0;
      full_ever      = 1'b1;
      if (full_on_run) begin
        full_run_ms = add_sat(full_run_ms, dt);
      end else begin
        full_on_run = 1'b1;
        full_run_ms = '0;
      end
    end else begin
      full_on_run = 1'b0;
      full_run_ms = '0;
    end
    pwr         = power_ever && (since_power_ms <= cfg_hold_ms);
    det_stable  = detect_on_run && (detect_run_ms >= cfg_stable_ms);
    full_steady = full_on_run && (full_run_ms >= cfg_stable_ms);
    alt         = pwr && detect_ever && full_ever &&
                  (since_detect_ms <= cfg_window_ms) && (since_full_ms <= cfg_window_ms);
    nobat       = alt && !det_stable && !full_steady;
    if (!pwr) begin
      st = ST_NO_POWER;
    end else if (full_steady && !nobat) begin
      st = ST_FULL;
    end else if (nobat) begin
      st = ST_BATT_MISSING;
    end else begin
      st = ST_CHARGING;
    end
    res         = make_status(st, 1'b0);
    res.changed = (res.status != prev_status);
    prev_status = res.status;
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    if (err_count < 100) begin
      $display("MISMATCH %s: expected %0d got %0d (cycle %0d)", what, want, got, cycle_count);
    end
    err_count++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_tick(input logic det_level, input logic full_level,
                           input logic [15:0] dt, input logic use_typed,
                           input tick_result_t typed_res);
    tick_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.detect_level <= det_level;
    in_ch.full_level   <= full_level;
    in_ch.elapsed_ms   <= dt;
    do @(posedge clk_i); while (!in_ch.ready);
    classify_tick(det_level, full_level, dt, predicted);
    status_expect_q.push_back(use_typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (status_expect_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_DETECT_LEVEL: cfg_active_level = val[0];
      CFG_POWER_HOLD:   cfg_hold_ms      = val;
      CFG_STABLE_HIGH:  cfg_stable_ms    = val;
      CFG_ALT_WINDOW:   cfg_window_ms    = val;
      default: ;
    endcase
  endtask

  // receiver backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    tick_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (status_expect_q.size() == 0) begin
        flag_mismatch("result with no request pending", 0, 1);
      end else begin
        want = status_expect_q.pop_front();
        if (out_ch.charge_state != want.status.charge_state)
          flag_mismatch("charge_state", want.status.charge_state, out_ch.charge_state);
        if (out_ch.power_good != want.status.power_good)
          flag_mismatch("power_good", want.status.power_good, out_ch.power_good);
        if (out_ch.charging != want.status.charging)
          flag_mismatch("charging", want.status.charging, out_ch.charging);
        if (out_ch.battery_full != want.status.battery_full)
          flag_mismatch("battery_full", want.status.battery_full, out_ch.battery_full);
        if (out_ch.batt_missing != want.status.batt_missing)
          flag_mismatch("batt_missing", want.status.batt_missing, out_ch.batt_missing);
        if (out_ch.status_changed != want.changed)
          flag_mismatch("status_changed", want.changed, out_ch.status_changed);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("charger_status_classifier test failed");
    $finish;
  end

  initial begin
    pin_pattern_e pattern;
    int unsigned  burst_left;
    int unsigned  r;
    logic         det_on;
    logic         full_on;
    logic         alt_tog;
    logic [15:0]  dt;
    logic [15:0]  level_val;
    logic [15:0]  hold_val;
    logic [15:0]  stable_val;
    logic [15:0]  window_val;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= CFG_DETECT_LEVEL;
    cfg_wdata_i        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.detect_level <= 1'b0;
    in_ch.full_level   <= 1'b0;
    in_ch.elapsed_ms   <= '0;
    send_idle_pct    = 31;
    recv_idle_pct    = 53;
    cfg_active_level = RST_DETECT_LEVEL;
    cfg_hold_ms      = RST_POWER_HOLD;
    cfg_stable_ms    = RST_STABLE_HIGH;
    cfg_window_ms    = RST_ALT_WINDOW;
    since_power_ms   = '0;
    since_detect_ms  = '0;
    since_full_ms    = '0;
    detect_run_ms    = '0;
    full_run_ms      = '0;
    power_ever       = 1'b0;
    detect_ever      = 1'b0;
    full_ever        = 1'b0;
    detect_on_run    = 1'b0;
    full_on_run      = 1'b0;
    prev_status      = '0;
    burst_left       = 0;
    alt_tog          = 1'b0;
    pattern          = PIN_QUIET;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) begin
      send_tick(DIRECTED[i].det_level, DIRECTED[i].full_level, DIRECTED[i].dt,
                DIRECTED[i].typed,
                make_status(DIRECTED[i].want_state, DIRECTED[i].want_changed));
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      hold_until_drained();
      case (phase)
        0: begin
          level_val = 16'd1; hold_val = 16'd1000; stable_val = 16'd400; window_val = 16'd1500;
        end
        1: begin
          level_val = 16'd0; hold_val = 16'd0; stable_val = 16'd0; window_val = 16'd0;
        end
        2: begin
          level_val = 16'd1; hold_val = 16'd60000; stable_val = 16'd60000;
          window_val = 16'd60000;
        end
        3: begin
          // saturated ages still count as within these thresholds
          level_val = 16'd0; hold_val = AGE_MAX; stable_val = AGE_MAX; window_val = AGE_MAX;
        end
        4: begin
          // upper bits of the level write must be dropped
          level_val  = 16'($urandom_range(0, 65535));
          hold_val   = 16'($urandom_range(0, 3000));
          stable_val = 16'($urandom_range(0, 1000));
          window_val = 16'($urandom_range(0, 3000));
        end
        default: begin
          level_val = 16'd1; hold_val = 16'd500; stable_val = 16'd50; window_val = 16'd800;
        end
      endcase
      write_reg(CFG_DETECT_LEVEL, level_val);
      write_reg(CFG_POWER_HOLD, hold_val);
      write_reg(CFG_STABLE_HIGH, stable_val);
      write_reg(CFG_ALT_WINDOW, window_val);
      @(negedge clk_i);
      cfg_we_i <= 1'b0;

      case (phase / 2)
        0: begin send_idle_pct = 31; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          r = $urandom_range(0, 9);
          case (r)
            0, 1:    pattern = PIN_CHARGE;
            2, 3:    pattern = PIN_FULL;
            4, 5, 6: pattern = PIN_ALTERNATE;
            7:       pattern = PIN_QUIET;
            8:       pattern = PIN_BOTH;
            default: pattern = PIN_NOISE;
          endcase
          burst_left = $urandom_range(2, 40);
        end
        burst_left--;
        if ($urandom_range(0, 3) != 0) alt_tog = ~alt_tog;
        case (pattern)
          PIN_CHARGE:    begin det_on = 1'b1;    full_on = 1'b0;     end
          PIN_FULL:      begin det_on = 1'b0;    full_on = 1'b1;     end
          PIN_ALTERNATE: begin det_on = alt_tog; full_on = ~alt_tog; end
          PIN_QUIET:     begin det_on = 1'b0;    full_on = 1'b0;     end
          PIN_BOTH:      begin det_on = 1'b1;    full_on = 1'b1;     end
          default: begin
            det_on  = 1'($urandom_range(0, 1));
            full_on = 1'($urandom_range(0, 1));
          end
        endcase
        // occasional glitch on a pin
        if ($urandom_range(0, 19) == 0) det_on = ~det_on;
        if ($urandom_range(0, 19) == 0) full_on = ~full_on;

        r = $urandom_range(0, 99);
        if (r < 5) begin
          dt = '0;
        end else if (r < 9) begin
          dt = AGE_MAX;
        end else if (r < 16) begin
          dt = 16'($urandom);
        end else if (r < 30) begin
          dt = 16'($urandom_range(0, 30000));
        end else begin
          dt = 16'($urandom_range(0, 600));
        end

        // sender holds off once per phase until everything is back
        if (n == ITEMS_PER_PHASE / 2) hold_until_drained();
        send_tick(det_on ? cfg_active_level : ~cfg_active_level, full_on, dt, 1'b0, '0);
      end
    end

    hold_until_drained();
    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("charger_status_classifier test passed");
    end else begin
      $display("charger_status_classifier test failed");
    end
    $finish;
  end

endmodule
